[rtl/sgb_pkg.sv]
`timescale 1ns / 1ps

package sgb_pkg;

  // fixed geometry of the coordinate fields and of the grid
  localparam int COORD_W   = 10;
  localparam int GRID_ROWS = 12;
  localparam int GRID_COLS = 8;
  localparam int ROW_W     = 4;
  localparam int COL_W     = 3;
  // scaled offsets: 11 * 1023 < 2**14, quotient below 16
  localparam int REM_W     = COORD_W + 4;
  localparam int QUO_W     = 4;

  localparam logic [REM_W-1:0] COL_SCALE = REM_W'(7);
  localparam logic [REM_W-1:0] ROW_SCALE = REM_W'(11);
  localparam logic [COL_W-1:0] COL_FLAT  = COL_W'(4);
  localparam logic [ROW_W-1:0] ROW_FLAT  = ROW_W'(6);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(GRID_ROWS - 1);

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_RAST  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_type_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row_index;
    logic [GRID_COLS-1:0] row_bits;
    logic                 last_row;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic add_pt;
    logic clear;
    logic begin_rast;
    logic fetch;
    logic load;
    logic div_step;
    logic mark;
    logic emit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic last_point;
    logic div_last;
    logic row_last;
  } dp_stat_t;

endpackage

[rtl/sgb_ctrl.sv]
`timescale 1ns / 1ps

module sgb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          req_type,
  input  sgb_pkg::dp_stat_t   stat,
  output sgb_pkg::ctl_cmd_t   ctl,
  output logic                busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_DIV,
    S_MARK,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (req_type)
            sgb_pkg::REQ_ADD:   ctl.add_pt = 1'b1;
            sgb_pkg::REQ_CLEAR: ctl.clear  = 1'b1;
            sgb_pkg::REQ_RAST: begin
              ctl.begin_rast = 1'b1;
              state_next     = stat.count_zero ? S_EMIT : S_FETCH;
            end
            default: ;  // unused code, ignored
          endcase
        end
      end
      S_FETCH: begin
        ctl.fetch  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        ctl.load   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (stat.div_last) state_next = S_MARK;
      end
      S_MARK: begin
        ctl.mark   = 1'b1;
        state_next = stat.last_point ? S_EMIT : S_FETCH;
      end
      S_EMIT: begin
        ctl.emit = 1'b1;
        if (stat.row_last) begin
          ctl.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

[rtl/sgb_datapath.sv]
`timescale 1ns / 1ps

module sgb_datapath #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  sgb_pkg::cmd_t       cmd,
  input  sgb_pkg::ctl_cmd_t   ctl,
  output sgb_pkg::dp_stat_t   stat,
  output sgb_pkg::result_t    result,
  output logic                result_strobe
);

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int XW  = sgb_pkg::COORD_W;
  localparam int RW  = sgb_pkg::REM_W;
  localparam int QW  = sgb_pkg::QUO_W;
  localparam int PW  = 2 * XW;
  localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);

  logic [PW-1:0] point_store [MAX_POINTS];
  logic [PW-1:0] rd_data;

  logic [CW-1:0] point_count;
  logic [XW-1:0] box_left, box_right, box_top, box_bottom;
  logic [sgb_pkg::GRID_COLS-1:0] grid_bits [sgb_pkg::GRID_ROWS];

  logic [AW-1:0] idx;
  logic [XW-1:0] dx, dy;
  logic [RW-1:0] rem_x, rem_y;
  logic [QW-1:0] quo_x, quo_y;
  logic [1:0]    step;
  logic [sgb_pkg::ROW_W-1:0] row_ctr;

  logic          add_ok;
  logic [XW-1:0] off_x, off_y;
  logic [RW-1:0] div_x, div_y;
  logic [sgb_pkg::COL_W-1:0] col_sel;
  logic [sgb_pkg::ROW_W-1:0] row_sel;

  assign add_ok = ctl.add_pt && (point_count != FULL);

  // stored points always lie inside the box
  assign off_x = rd_data[PW-1:XW] - box_left;
  assign off_y = rd_data[XW-1:0]  - box_top;

  assign div_x = RW'(dx) << step;
  assign div_y = RW'(dy) << step;

  assign col_sel = (dx == '0) ? sgb_pkg::COL_FLAT : quo_x[sgb_pkg::COL_W-1:0];
  always_comb begin
    if (dy == '0) begin
      row_sel = sgb_pkg::ROW_FLAT;
    end else if (quo_y > sgb_pkg::ROW_LAST) begin
      row_sel = sgb_pkg::ROW_LAST;
    end else begin
      row_sel = quo_y;
    end
  end

  // point memory
  always_ff @(posedge clk) begin
    if (add_ok) point_store[point_count[AW-1:0]] <= {cmd.point_x, cmd.point_y};
    if (ctl.fetch) rd_data <= point_store[idx];
  end

  // control state: count, box, grid, strobe
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      point_count <= '0;
      box_left    <= '1;
      box_right   <= '0;
      box_top     <= '1;
      box_bottom  <= '0;
      for (int r = 0; r < sgb_pkg::GRID_ROWS; r++) grid_bits[r] <= '0;
    end else begin
      if (add_ok) begin
        point_count <= point_count + CW'(1);
        if (cmd.point_x < box_left)   box_left   <= cmd.point_x;
        if (cmd.point_x > box_right)  box_right  <= cmd.point_x;
        if (cmd.point_y < box_top)    box_top    <= cmd.point_y;
        if (cmd.point_y > box_bottom) box_bottom <= cmd.point_y;
      end
      if (ctl.mark) grid_bits[row_sel][col_sel] <= 1'b1;
    end
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= ctl.emit;
    end
  end

  // walk and divide
  always_ff @(posedge clk) begin
    if (ctl.begin_rast) begin
      idx     <= '0;
      row_ctr <= '0;
      dx      <= box_right - box_left;
      dy      <= box_bottom - box_top;
    end
    if (ctl.load) begin
      rem_x <= RW'(off_x) * sgb_pkg::COL_SCALE;
      rem_y <= RW'(off_y) * sgb_pkg::ROW_SCALE;
      quo_x <= '0;
      quo_y <= '0;
      step  <= 2'd3;
    end
    if (ctl.div_step) begin
      if (rem_x >= div_x) begin
        rem_x       <= rem_x - div_x;
        quo_x[step] <= 1'b1;
      end
      if (rem_y >= div_y) begin
        rem_y       <= rem_y - div_y;
        quo_y[step] <= 1'b1;
      end
      step <= step - 2'd1;
    end
    if (ctl.mark) idx <= idx + AW'(1);
    if (ctl.emit) begin
      result.row_index <= row_ctr;
      result.row_bits  <= grid_bits[row_ctr];
      result.last_row  <= (row_ctr == sgb_pkg::ROW_LAST);
      row_ctr          <= row_ctr + sgb_pkg::ROW_W'(1);
    end
  end

  assign stat.count_zero = (point_count == '0);
  assign stat.last_point = ((CW'(idx) + CW'(1)) == point_count);
  assign stat.div_last   = (step == 2'd0);
  assign stat.row_last   = (row_ctr == sgb_pkg::ROW_LAST);

endmodule

[rtl/stroke_to_grid_bitmap_core.sv]
`timescale 1ns / 1ps

// channel   | handshake                  | payload
// ----------+----------------------------+-----------------------------------
// request   | start, busy (taken when    | cmd: req_type, point_x, point_y
//           | start high and busy low)   |
// result    | result_strobe, one cycle,  | result: row_index, row_bits,
//           | no back-pressure           | last_row
//
// Add and clear leave busy low. Rasterise holds busy while it walks the N
// stored points: per point one memory read, one load of
// the scaled offsets, four restoring divide steps, one grid mark; then twelve
// rows, one per cycle, each shown on the cycle after it is read out.
// Synchronous reset empties the store count, the box and the grid; the point
// memory itself is never cleared. Results cannot be held off.

module stroke_to_grid_bitmap_core #(
  parameter int MAX_POINTS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sgb_pkg::cmd_t     cmd,
  output sgb_pkg::result_t  result,
  output logic              result_strobe
);

  // command and status between the sequencer and the datapath
  sgb_pkg::ctl_cmd_t ctl;
  sgb_pkg::dp_stat_t stat;

  // sequencer: idle / fetch / load / divide / mark / emit
  sgb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (cmd.req_type),
    .stat     (stat),
    .ctl      (ctl),
    .busy     (busy)
  );

  // point memory, box, shared divider pair and row bitmaps
  sgb_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .ctl           (ctl),
    .stat          (stat),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule

[sim/tb_stroke_to_grid_bitmap_core.sv]
`timescale 1ns / 1ps

module tb_stroke_to_grid_bitmap_core;

  localparam int CAPACITY     = 1024;   // point store depth of the instance
  localparam int IDLE_LIMIT   = 50000;  // idle cycles the watchdog allows before it ends the run
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 320;
  localparam int SHOW_LIMIT   = 10;
  localparam int CMD_W        = $bits(sgb_pkg::cmd_t);

  // grid scaling: columns span 0..7, rows 0..11, flat box lands mid-grid
  localparam int COL_STEPS = 7;
  localparam int ROW_STEPS = 11;
  localparam int COL_MID   = 4;
  localparam int ROW_MID   = 6;

  localparam logic [1:0]                  REQ_UNUSED = 2'd3;
  localparam logic [sgb_pkg::COORD_W-1:0] COORD_MAX  = '1;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  sgb_pkg::cmd_t    cmd;
  sgb_pkg::result_t result;
  logic             result_strobe;

  stroke_to_grid_bitmap_core #(
    .MAX_POINTS(CAPACITY)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .result        (result),
    .result_strobe (result_strobe)
  );

  // shadow of the stroke: stored points and bounding box
  logic [sgb_pkg::COORD_W-1:0] pt_x [CAPACITY];
  logic [sgb_pkg::COORD_W-1:0] pt_y [CAPACITY];
  int                          pt_count;
  logic [sgb_pkg::COORD_W-1:0] box_l, box_r, box_t, box_b;

  sgb_pkg::result_t rows_due [$];  // grid rows still to come out, oldest first

  int  fail_count    = 0;
  int  adds_taken    = 0;
  int  rasters_taken = 0;
  int  rows_seen     = 0;
  bit  no_gaps       = 1'b0;  // sender runs flat out while set

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void empty_stroke();
    pt_count = 0;
    box_l    = COORD_MAX;
    box_r    = '0;
    box_t    = COORD_MAX;
    box_b    = '0;
  endfunction

  // Map every stored point into the grid, queue the twelve rows, then empty.
  function automatic void predict_grid_rows();
    logic [sgb_pkg::GRID_COLS-1:0] grid [sgb_pkg::GRID_ROWS];
    int               width, height, off, col, row;
    sgb_pkg::result_t r;
    width  = (box_r >= box_l) ? int'(box_r) - int'(box_l) : int'(box_l) - int'(box_r);
    height = (box_b >= box_t) ? int'(box_b) - int'(box_t) : int'(box_t) - int'(box_b);
    foreach (grid[g]) grid[g] = '0;
    for (int i = 0; i < pt_count; i++) begin
      if (width != 0) begin
        off = (pt_x[i] >= box_l) ? int'(pt_x[i]) - int'(box_l) : int'(box_l) - int'(pt_x[i]);
        col = (COL_STEPS * off) / width;
      end else begin
        col = COL_MID;
      end
      if (height != 0) begin
        off = (pt_y[i] >= box_t) ? int'(pt_y[i]) - int'(box_t) : int'(box_t) - int'(pt_y[i]);
        row = (ROW_STEPS * off) / height;
      end else begin
        row = ROW_MID;
      end
      col = col & (sgb_pkg::GRID_COLS - 1);
      if (row > sgb_pkg::GRID_ROWS - 1) row = sgb_pkg::GRID_ROWS - 1;
      grid[row][col] = 1'b1;
    end
    for (int g = 0; g < sgb_pkg::GRID_ROWS; g++) begin
      r.row_index = sgb_pkg::ROW_W'(g);
      r.row_bits  = grid[g];
      r.last_row  = (g == sgb_pkg::GRID_ROWS - 1);
      rows_due    = {rows_due, r};
    end
    empty_stroke();
  endfunction

  function automatic void track_cmd(sgb_pkg::cmd_t c);
    case (c.req_type)
      sgb_pkg::REQ_ADD: begin
        // a full store drops the point and leaves the box alone
        if (pt_count < CAPACITY) begin
          pt_x[pt_count] = c.point_x;
          pt_y[pt_count] = c.point_y;
          pt_count++;
          adds_taken++;
          if (c.point_x < box_l) box_l = c.point_x;
          if (c.point_x > box_r) box_r = c.point_x;
          if (c.point_y < box_t) box_t = c.point_y;
          if (c.point_y > box_b) box_b = c.point_y;
        end
      end
      sgb_pkg::REQ_CLEAR: empty_stroke();
      sgb_pkg::REQ_RAST: begin
        predict_grid_rows();
        rasters_taken++;
      end
      default: ;  // unused code: nothing happens
    endcase
  endfunction

  // ------------------------------------------------------------------- driver

  // Unless no_gaps is set, idle with junk on cmd and start low; then hold start until busy is low.
  task automatic send_cmd(input logic [1:0] req, input logic [sgb_pkg::COORD_W-1:0] x,
                          input logic [sgb_pkg::COORD_W-1:0] y);
    sgb_pkg::cmd_t c;
    logic [CMD_W-1:0] junk;
    int               gap;
    c.req_type = req;
    c.point_x  = x;
    c.point_y  = y;
    gap        = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      junk = CMD_W'($urandom);
      start <= 1'b0;
      cmd   <= junk;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
    track_cmd(c);
  endtask

  // ------------------------------------------------------------------ checker

  function automatic void log_mismatch(string what, sgb_pkg::result_t exp,
                                       sgb_pkg::result_t act);
    fail_count++;
    if (fail_count <= SHOW_LIMIT)
      $display("%0t: %s: expected row %0d bits %b last %b, got row %0d bits %b last %b",
               $time, what, exp.row_index, exp.row_bits, exp.last_row,
               act.row_index, act.row_bits, act.last_row);
  endfunction

  // Outputs are read at the edge that ends their cycle, so pre-edge values.
  always @(posedge clk) begin
    sgb_pkg::result_t exp;
    if (!rst && result_strobe === 1'b1) begin
      rows_seen++;
      if (rows_due.size() == 0) begin
        log_mismatch("row with none outstanding", '0, result);
      end else begin
        exp = rows_due.pop_front();
        if (result.row_index !== exp.row_index || result.row_bits !== exp.row_bits ||
            result.last_row !== exp.last_row)
          log_mismatch("row mismatch", exp, result);
      end
    end
  end

  // Ends the run when neither a command nor a row has moved for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start === 1'b1 && busy === 1'b0) || result_strobe === 1'b1) idle = 0;
      else idle++;
    end
    $display("Timeout: no progress for %0d cycles", IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // -------------------------------------------------------------------- tests

  // Straight after reset: empty grid, requested twice in a row.
  task automatic test_empty_raster();
    send_cmd(sgb_pkg::REQ_RAST, COORD_MAX, COORD_MAX);
    send_cmd(sgb_pkg::REQ_RAST, '0, '0);
  endtask

  // One point gives a zero-size box in both axes: mid-grid cell.
  task automatic test_single_point();
    send_cmd(sgb_pkg::REQ_ADD, COORD_MAX, COORD_MAX);
    send_cmd(sgb_pkg::REQ_RAST, '0, '0);
  endtask

  // Zero width (vertical stroke), then zero height (horizontal stroke).
  task automatic test_flat_box();
    send_cmd(sgb_pkg::REQ_ADD, 10'd300, 10'd0);
    send_cmd(sgb_pkg::REQ_ADD, 10'd300, COORD_MAX);
    send_cmd(sgb_pkg::REQ_ADD, 10'd300, 10'd512);
    send_cmd(sgb_pkg::REQ_RAST, '0, '0);
    send_cmd(sgb_pkg::REQ_ADD, 10'd0, 10'd77);
    send_cmd(sgb_pkg::REQ_ADD, COORD_MAX, 10'd77);
    send_cmd(sgb_pkg::REQ_ADD, 10'd400, 10'd77);
    send_cmd(sgb_pkg::REQ_RAST, '0, '0);
  endtask

  // Full-range corners; the unused code carries a coordinate that would
  // widen the box were it taken as an add.
  task automatic test_corners_and_unused();
    send_cmd(sgb_pkg::REQ_ADD, 10'd500, 10'd500);
    send_cmd(REQ_UNUSED, COORD_MAX, 10'd0);
    send_cmd(sgb_pkg::REQ_ADD, 10'd510, 10'd520);
    send_cmd(sgb_pkg::REQ_RAST, '0, '0);
    send_cmd(sgb_pkg::REQ_ADD, 10'd0, 10'd0);
    send_cmd(sgb_pkg::REQ_ADD, COORD_MAX, COORD_MAX);
    send_cmd(sgb_pkg::REQ_ADD, 10'd0, COORD_MAX);
    send_cmd(sgb_pkg::REQ_ADD, COORD_MAX, 10'd0);
    send_cmd(sgb_pkg::REQ_ADD, 10'd511, 10'd700);
    send_cmd(sgb_pkg::REQ_RAST, '0, '0);
  endtask

  // Clear drops points and box; a lone point afterwards must sit mid-grid.
  task automatic test_clear();
    send_cmd(sgb_pkg::REQ_ADD, 10'd10, 10'd20);
    send_cmd(sgb_pkg::REQ_ADD, 10'd900, 10'd800);
    send_cmd(sgb_pkg::REQ_CLEAR, COORD_MAX, COORD_MAX);
    send_cmd(sgb_pkg::REQ_ADD, 10'd5, 10'd5);
    send_cmd(sgb_pkg::REQ_RAST, '0, '0);
    send_cmd(sgb_pkg::REQ_CLEAR, '0, '0);
    send_cmd(sgb_pkg::REQ_RAST, '0, '0);
  endtask

  function automatic int pick_spread();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return $urandom_range(1, 15);
      2, 3:    return $urandom_range(16, 300);
      default: return COORD_MAX;
    endcase
  endfunction

  // Mostly strokes of a few points ending in a rasterise; some longer ones,
  // some abandoned by a clear or merged into the next, unused codes as noise.
  task automatic test_random_strokes();
    int                          sent, kind, npts, spread_x, spread_y, base_x, base_y;
    logic [sgb_pkg::COORD_W-1:0] x, y;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_gaps  = ($urandom_range(0, 3) == 0);
      kind     = $urandom_range(0, 19);
      npts     = (kind < 14) ? $urandom_range(1, 10) :
                 (kind < 19) ? $urandom_range(11, 40) : 0;
      spread_x = pick_spread();
      spread_y = pick_spread();
      base_x   = $urandom_range(0, COORD_MAX - spread_x);
      base_y   = $urandom_range(0, COORD_MAX - spread_y);
      for (int i = 0; i < npts; i++) begin
        if ($urandom_range(0, 24) == 0)
          send_cmd(REQ_UNUSED, sgb_pkg::COORD_W'($urandom), sgb_pkg::COORD_W'($urandom));
        x = sgb_pkg::COORD_W'(base_x + $urandom_range(0, spread_x));
        y = sgb_pkg::COORD_W'(base_y + $urandom_range(0, spread_y));
        send_cmd(sgb_pkg::REQ_ADD, x, y);
        sent++;
      end
      kind = $urandom_range(0, 19);
      if (kind < 16) begin
        send_cmd(sgb_pkg::REQ_RAST, sgb_pkg::COORD_W'($urandom),
                 sgb_pkg::COORD_W'($urandom));
        sent++;
      end else if (kind < 19) begin
        send_cmd(sgb_pkg::REQ_CLEAR, sgb_pkg::COORD_W'($urandom),
                 sgb_pkg::COORD_W'($urandom));
        sent++;
      end
    end
    no_gaps = 1'b0;
    send_cmd(sgb_pkg::REQ_RAST, '0, '0);  // flush whatever stroke is left open
  endtask

  // --------------------------------------------------------------------- main

  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    empty_stroke();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_raster();
    test_single_point();
    test_flat_box();
    test_corners_and_unused();
    test_clear();
    test_random_strokes();
    start <= 1'b0;

    while (rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d stored points and %0d rasterise requests, with clears and flat boxes",
             adds_taken, rasters_taken);
    $display("Checked %0d grid rows, %0d mismatches", rows_seen, fail_count);
    if (fail_count == 0 && rows_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
